[hw/rtl/skt_pkg.sv]
`timescale 1ns / 1ps

package skt_pkg;

	localparam int CAPACITY_DEF      = 64;
	localparam int PAYLOAD_WIDTH_DEF = 32;

	localparam int KEY_W    = 32;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 2;
	localparam int PORT_PAY_W = 32;
	localparam int COUNT_OUT_W = 7;

	// Operation codes carried by the kind field.
	localparam logic [KIND_W-1:0] OP_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] OP_DELETE = 2'd1;
	localparam logic [KIND_W-1:0] OP_SEARCH = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	// Control broadcast from the top level to every cell.
	typedef struct packed {
		logic ins;
		logic del;
	} cell_ctl_t;

endpackage

[hw/rtl/skt_cell.sv]
`timescale 1ns / 1ps

module skt_cell #(
	parameter int PAY_W = skt_pkg::PAYLOAD_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              occupied,
	input  logic                              cmp_en,
	input  logic signed [skt_pkg::KEY_W-1:0]  cmp_key,
	input  logic                              lt_left,
	input  logic signed [skt_pkg::KEY_W-1:0]  left_key,
	input  logic        [PAY_W-1:0]           left_pay,
	input  logic signed [skt_pkg::KEY_W-1:0]  right_key,
	input  logic        [PAY_W-1:0]           right_pay,
	input  logic signed [skt_pkg::KEY_W-1:0]  new_key,
	input  logic        [PAY_W-1:0]           new_pay,
	input  skt_pkg::cell_ctl_t                ctl,
	output logic                              lt,
	output logic                              hit,
	output logic signed [skt_pkg::KEY_W-1:0]  key,
	output logic        [PAY_W-1:0]           pay
);

	logic signed [skt_pkg::KEY_W-1:0] key_q;
	logic        [PAY_W-1:0]          pay_q;
	logic                             lt_q;
	logic                             eq_q;

	// Compare against the key of the item being accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (cmp_en) begin
			lt_q <= occupied && (key_q < cmp_key);
			eq_q <= occupied && (key_q == cmp_key);
		end
	end

	// Cells that are not below the key form the tail that moves. On insert the first of
	// them takes the new entry and the rest their left neighbor; on delete each takes its right neighbor.
	always_ff @(posedge clk) begin
		if (ctl.ins && !lt_q) begin
			key_q <= lt_left ? new_key : left_key;
			pay_q <= lt_left ? new_pay : left_pay;
		end else if (ctl.del && !lt_q) begin
			key_q <= right_key;
			pay_q <= right_pay;
		end
	end

	assign lt  = lt_q;
	assign hit = lt_left && !lt_q && eq_q;
	assign key = key_q;
	assign pay = pay_q;

endmodule

[hw/rtl/sorted_key_table_top.sv]
`timescale 1ns / 1ps

// Channel  Valid      Stall      Fields
// input    in_valid   in_stall   kind, key_value, payload_in
// output   out_valid  out_stall  status, payload_out, entry_count
//
// For each item, every cell compares its key to the incoming key at the accepting
// edge; when the item fires the row shifts and the result is registered. No new item
// is taken until the current one has fired.
// Reset clears the entry count and the handshake state; entry storage is not cleared.
// A stalled result holds back the shift and result of the next item until it is taken.
module sorted_key_table_top #(
	parameter int CAPACITY      = skt_pkg::CAPACITY_DEF,
	parameter int PAYLOAD_WIDTH = skt_pkg::PAYLOAD_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic        [skt_pkg::KIND_W-1:0]     kind,
	input  logic signed [skt_pkg::KEY_W-1:0]      key_value,
	input  logic        [skt_pkg::PORT_PAY_W-1:0] payload_in,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic        [skt_pkg::STATUS_W-1:0]   status,
	output logic        [skt_pkg::PORT_PAY_W-1:0] payload_out,
	output logic        [skt_pkg::COUNT_OUT_W-1:0] entry_count
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic                             busy_q;
	logic [skt_pkg::KIND_W-1:0]       kind_s1;
	logic signed [skt_pkg::KEY_W-1:0] key_s1;
	logic [PAYLOAD_WIDTH-1:0]         pay_s1;
	logic [CNT_W-1:0]                 count_q;

	logic                             out_valid_q;
	logic [skt_pkg::STATUS_W-1:0]     status_q;
	logic [skt_pkg::PORT_PAY_W-1:0]   payload_out_q;
	logic [skt_pkg::COUNT_OUT_W-1:0]  entry_count_q;

	logic                             in_accept;
	logic                             fire;
	logic                             full;
	logic                             found;
	logic [PAYLOAD_WIDTH-1:0]         pay_in_w;
	logic [PAYLOAD_WIDTH-1:0]         sel_pay;
	logic [skt_pkg::PORT_PAY_W-1:0]   sel_pay_port;
	logic [CNT_W-1:0]                 count_next;
	logic [skt_pkg::COUNT_OUT_W-1:0]  count_port;
	logic [skt_pkg::STATUS_W-1:0]     status_next;
	skt_pkg::cell_ctl_t               ctl;

	logic        [CAPACITY-1:0]       cell_lt;
	logic        [CAPACITY-1:0]       cell_hit;
	logic signed [skt_pkg::KEY_W-1:0] cell_key [CAPACITY];
	logic        [PAYLOAD_WIDTH-1:0]  cell_pay [CAPACITY];

	assign in_stall  = busy_q;
	assign in_accept = in_valid && !busy_q;
	assign fire      = busy_q && (!out_valid_q || !out_stall);
	assign full      = (count_q == CNT_W'(CAPACITY));

	generate
		if (PAYLOAD_WIDTH <= skt_pkg::PORT_PAY_W) begin : g_pay_narrow
			assign pay_in_w     = payload_in[PAYLOAD_WIDTH-1:0];
			assign sel_pay_port = skt_pkg::PORT_PAY_W'(sel_pay);
		end else begin : g_pay_wide
			assign pay_in_w     = {{(PAYLOAD_WIDTH - skt_pkg::PORT_PAY_W){1'b0}}, payload_in};
			assign sel_pay_port = sel_pay[skt_pkg::PORT_PAY_W-1:0];
		end
		if (CNT_W >= skt_pkg::COUNT_OUT_W) begin : g_cnt_wide
			assign count_port = count_next[skt_pkg::COUNT_OUT_W-1:0];
		end else begin : g_cnt_narrow
			assign count_port = {{(skt_pkg::COUNT_OUT_W - CNT_W){1'b0}}, count_next};
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (in_accept) begin
			kind_s1 <= kind;
			key_s1  <= key_value;
			pay_s1  <= pay_in_w;
		end
	end

	// The row of cells. Cell 0 sees an always-below left neighbor so that it
	// takes the new entry when the key belongs at the front.
	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			logic                             lt_left;
			logic signed [skt_pkg::KEY_W-1:0] left_key;
			logic        [PAYLOAD_WIDTH-1:0]  left_pay;
			logic signed [skt_pkg::KEY_W-1:0] right_key;
			logic        [PAYLOAD_WIDTH-1:0]  right_pay;

			if (gi == 0) begin : g_first
				assign lt_left  = 1'b1;
				assign left_key = key_s1;
				assign left_pay = pay_s1;
			end else begin : g_mid
				assign lt_left  = cell_lt[gi-1];
				assign left_key = cell_key[gi-1];
				assign left_pay = cell_pay[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_last
				assign right_key = key_s1;
				assign right_pay = pay_s1;
			end else begin : g_inner
				assign right_key = cell_key[gi+1];
				assign right_pay = cell_pay[gi+1];
			end

			skt_cell #(
				.PAY_W(PAYLOAD_WIDTH)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.occupied (count_q > CNT_W'(gi)),
				.cmp_en   (in_accept),
				.cmp_key  (key_value),
				.lt_left  (lt_left),
				.left_key (left_key),
				.left_pay (left_pay),
				.right_key(right_key),
				.right_pay(right_pay),
				.new_key  (key_s1),
				.new_pay  (pay_s1),
				.ctl      (ctl),
				.lt       (cell_lt[gi]),
				.hit      (cell_hit[gi]),
				.key      (cell_key[gi]),
				.pay      (cell_pay[gi])
			);
		end
	endgenerate

	// At most one cell sits at the lower bound, so an OR picks its payload.
	always_comb begin
		sel_pay = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			sel_pay = sel_pay | (cell_hit[i] ? cell_pay[i] : '0);
		end
	end

	assign found = |cell_hit;

	always_comb begin
		ctl.ins     = 1'b0;
		ctl.del     = 1'b0;
		count_next  = count_q;
		status_next = skt_pkg::ST_DONE;
		unique case (kind_s1)
			skt_pkg::OP_INSERT: begin
				if (full) begin
					status_next = skt_pkg::ST_FULL;
				end else begin
					ctl.ins    = fire;
					count_next = count_q + CNT_W'(1);
				end
			end
			skt_pkg::OP_DELETE: begin
				if (found) begin
					ctl.del    = fire;
					count_next = count_q - CNT_W'(1);
				end else begin
					status_next = skt_pkg::ST_MISS;
				end
			end
			skt_pkg::OP_SEARCH: begin
				if (!found) begin
					status_next = skt_pkg::ST_MISS;
				end
			end
			default: begin
				status_next = skt_pkg::ST_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				busy_q <= 1'b1;
			end else if (fire) begin
				busy_q <= 1'b0;
			end
			if (fire) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q      <= status_next;
			payload_out_q <= (kind_s1 == skt_pkg::OP_SEARCH && found) ? sel_pay_port : '0;
			entry_count_q <= count_port;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign payload_out = payload_out_q;
	assign entry_count = entry_count_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count beyond capacity");

	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> $onehot0(cell_hit))
		else $error("more than one cell at the lower bound");

	a_fire_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("finished item left no result");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == skt_pkg::ST_FULL) |-> full)
		else $error("full status reported on a table that is not full");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == skt_pkg::ST_MISS) |-> (payload_out_q == '0))
		else $error("payload shown on a miss");

endmodule
